// ----- src/cylinder_sphere_overlap_top_defines.svh -----
// Assertion macros for the sphere and cylinder overlap block.
// Used by the top level only; they need clk and rst_n in scope.
`ifndef CYLINDER_SPHERE_OVERLAP_TOP_DEFINES_SVH
`define CYLINDER_SPHERE_OVERLAP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CSO_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CSO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSO_ASSERT_IMPL(lbl, ante, cons)
`define CSO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/cso_pkg.sv -----
// Shared types and widths for the sphere and cylinder overlap block.
// No dependencies; used by cso_isqrt and the top level.
`default_nettype none
package cso_pkg;
    localparam int ROOT_W = 32;
    localparam int RAD_W  = 31;
    localparam int P4_W   = 68;

    typedef struct packed {
        logic              rej1;
        logic              rej2;
        logic              in2;
        logic              in4;
        logic [P4_W-1:0]   perp4;
        logic [RAD_W-1:0]  r;
    } side_t;
endpackage
`default_nettype wire

// ----- src/cso_isqrt.sv -----
// Pipelined 64-bit integer square root, one result bit per stage.
// Depends on cso_pkg for the side payload carried alongside.
`default_nettype none
module cso_isqrt
    import cso_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [63:0]       in_value,
    input  wire side_t             in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output side_t                  out_side
);
    logic        v_reg    [ROOT_W];
    logic [63:0] x_reg    [ROOT_W];
    logic [63:0] res_reg  [ROOT_W];
    side_t       side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
        logic        v_in;
        logic [63:0] x_in;
        logic [63:0] res_in;
        side_t       side_in;
        logic [64:0] trial;
        logic [63:0] x_next;
        logic [63:0] res_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign x_in    = in_value;
            assign res_in  = '0;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign v_in    = v_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            trial = {1'b0, res_in} + {1'b0, BIT};
            if ({1'b0, x_in} >= trial)
            begin
                x_next   = x_in - trial[63:0];
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                x_next   = x_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= x_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = res_reg[ROOT_W-1][ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_W-1];
endmodule
`default_nettype wire

// ----- src/cylinder_sphere_overlap_top.sv -----
// Top level of the sphere versus capped cylinder overlap test.
// Depends on cso_pkg, cso_isqrt and cylinder_sphere_overlap_top_defines.svh.
//
// One query enters per cycle while the input is not stalled. The path has 43
// registers: ten arithmetic stages, a 32-stage square root that settles one
// root bit per stage, and the output register, from which the hit flag leaves.
// The first of them is loaded at the accepting edge. A skid register behind
// the pipeline catches one finished result while the output is held. The
// pipeline and the input stall only while that register is occupied.
`default_nettype none
`include "cylinder_sphere_overlap_top_defines.svh"
module cylinder_sphere_overlap_top
    import cso_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cyl_center_x, cyl_center_y, cyl_center_z, axis_x, axis_y, axis_z,
    // cyl_height, cyl_radius, ball_center_x, ball_center_y, ball_center_z,
    // ball_radius, zero fill.
    input  wire logic [335:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // overlap, zero fill.
    output logic [7:0]        m_tdata
);
    localparam int CW_EFF = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam int SH     = 32 - CW_EFF;

    logic en;
    logic skid_valid_reg;
    logic skid_bit_reg;
    logic out_valid_reg;
    logic out_bit_reg;

    assign en = !skid_valid_reg;

    logic [31:0] cyl_c  [3];
    logic [31:0] ball_c [3];
    logic [15:0] axis   [3];
    assign cyl_c[0]  = s_tdata[31:0];
    assign cyl_c[1]  = s_tdata[63:32];
    assign cyl_c[2]  = s_tdata[95:64];
    assign axis[0]   = s_tdata[111:96];
    assign axis[1]   = s_tdata[127:112];
    assign axis[2]   = s_tdata[143:128];
    assign ball_c[0] = s_tdata[237:206];
    assign ball_c[1] = s_tdata[269:238];
    assign ball_c[2] = s_tdata[301:270];

    // Stage 1: differences.
    logic               v1_reg;
    logic signed [32:0] d1_reg  [3];
    logic        [32:0] dm1_reg [3];
    logic signed [15:0] a1_reg  [3];
    logic [RAD_W-1:0]   h1_reg, r1_reg, br1_reg;
    logic signed [32:0] d1_next  [3];
    logic        [32:0] dm1_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_next[i] = 33'(signed'(cyl_c[i] << SH) >>> SH);
            d1_next[i] = 33'(signed'(ball_c[i] << SH) >>> SH) - d1_next[i];
            dm1_next[i] = d1_next[i][32] ? 33'(-d1_next[i]) : 33'(d1_next[i]);
        end
    end

    // Stage 2: products.
    logic               v2_reg;
    logic signed [49:0] p2_reg  [3];
    logic        [64:0] sq2_reg [3];
    logic [RAD_W-1:0]   h2_reg, r2_reg, br2_reg;

    // Stage 3: sums.
    logic               v3_reg;
    logic signed [51:0] proj3_reg;
    logic        [65:0] d2_3_reg;
    logic [RAD_W-1:0]   h3_reg, r3_reg, br3_reg;

    // Stage 4: rounded projection magnitude, saturated.
    logic               v4_reg;
    logic [32:0]        ap4_reg;
    logic [65:0]        d2_4_reg;
    logic [RAD_W-1:0]   h4_reg, r4_reg, br4_reg;
    logic [51:0]        pm4;
    logic [37:0]        ap4_full;

    always_comb
    begin
        pm4      = proj3_reg[51] ? 52'(-proj3_reg) : 52'(proj3_reg);
        ap4_full = 38'((pm4 + 52'd8192) >> 14);
    end

    // Stage 5: cap tests and squares of radii.
    logic               v5_reg, rej1_5_reg, in2_5_reg;
    logic [65:0]        ap2_5_reg, d2_5_reg;
    logic [63:0]        rb2_5_reg;
    logic [61:0]        rr_5_reg;
    logic [31:0]        dist5_reg, twobr5_reg;
    logic [RAD_W-1:0]   r5_reg;
    logic [33:0]        twoap5;
    logic [31:0]        rb5;

    always_comb
    begin
        twoap5 = {ap4_reg, 1'b0};
        rb5    = 32'(r4_reg) + 32'(br4_reg);
    end

    // Stage 6: distance from the axis and cut circle terms.
    logic               v6_reg, rej1_6_reg, in2_6_reg;
    logic [65:0]        perp6_reg;
    logic [63:0]        rb2_6_reg, dsq6_reg, bsq6_reg;
    logic [61:0]        rr_6_reg;
    logic [RAD_W-1:0]   r6_reg;

    // Stage 7: radial tests and square root operand.
    logic               v7_reg;
    side_t              side7_reg;
    logic [63:0]        w7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]  <= d1_next[i];
                dm1_reg[i] <= dm1_next[i];
                a1_reg[i]  <= axis[i];
                p2_reg[i]  <= 50'(d1_reg[i]) * 50'(a1_reg[i]);
                sq2_reg[i] <= 65'(dm1_reg[i]) * 65'(dm1_reg[i]);
            end
            h1_reg  <= s_tdata[174:144];
            r1_reg  <= s_tdata[205:175];
            br1_reg <= s_tdata[332:302];
            h2_reg  <= h1_reg;
            r2_reg  <= r1_reg;
            br2_reg <= br1_reg;

            proj3_reg <= 52'(p2_reg[0]) + 52'(p2_reg[1]) + 52'(p2_reg[2]);
            d2_3_reg  <= 66'(sq2_reg[0]) + 66'(sq2_reg[1]) + 66'(sq2_reg[2]);
            h3_reg    <= h2_reg;
            r3_reg    <= r2_reg;
            br3_reg   <= br2_reg;

            ap4_reg  <= (ap4_full[37:33] != '0) ? '1 : ap4_full[32:0];
            d2_4_reg <= d2_3_reg;
            h4_reg   <= h3_reg;
            r4_reg   <= r3_reg;
            br4_reg  <= br3_reg;

            rej1_5_reg <= twoap5 > (34'(h4_reg) + {2'b0, br4_reg, 1'b0});
            in2_5_reg  <= twoap5 <= 34'(h4_reg);
            ap2_5_reg  <= 66'(ap4_reg) * 66'(ap4_reg);
            rb2_5_reg  <= 64'(rb5) * 64'(rb5);
            rr_5_reg   <= 62'(r4_reg) * 62'(r4_reg);
            dist5_reg  <= 32'(twoap5 - 34'(h4_reg));
            twobr5_reg <= {br4_reg, 1'b0};
            d2_5_reg   <= d2_4_reg;
            r5_reg     <= r4_reg;

            rej1_6_reg <= rej1_5_reg;
            in2_6_reg  <= in2_5_reg;
            perp6_reg  <= (d2_5_reg > ap2_5_reg) ? d2_5_reg - ap2_5_reg : '0;
            rb2_6_reg  <= rb2_5_reg;
            rr_6_reg   <= rr_5_reg;
            dsq6_reg   <= 64'(dist5_reg) * 64'(dist5_reg);
            bsq6_reg   <= 64'(twobr5_reg) * 64'(twobr5_reg);
            r6_reg     <= r5_reg;

            side7_reg.rej1  <= rej1_6_reg;
            side7_reg.rej2  <= perp6_reg > 66'(rb2_6_reg);
            side7_reg.in2   <= in2_6_reg;
            side7_reg.in4   <= perp6_reg <= 66'(rr_6_reg);
            side7_reg.perp4 <= {perp6_reg, 2'b00};
            side7_reg.r     <= r6_reg;
            w7_reg          <= bsq6_reg - dsq6_reg;
        end
    end

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    cso_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .in_value  (w7_reg),
        .in_side   (side7_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Stages 8 to 10: cut circle reach, its square, and the decision.
    logic               v8_reg, v9_reg, v10_reg;
    logic [32:0]        s8_reg;
    side_t              side8_reg, side9_reg;
    logic [65:0]        ssq9_reg;
    logic               fin10_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else if (en)
        begin
            v8_reg  <= sq_valid;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_reg    <= {1'b0, sq_side.r, 1'b0} + 33'(sq_root);
            side8_reg <= sq_side;
            ssq9_reg  <= 66'(s8_reg) * 66'(s8_reg);
            side9_reg <= side8_reg;
            fin10_reg <= !side9_reg.rej1 && !side9_reg.rej2 &&
                         (side9_reg.in2 || side9_reg.in4 ||
                          (side9_reg.perp4 <= 68'(ssq9_reg)));
        end
    end

    logic take;
    assign take = v10_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= take;
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_bit_reg <= skid_bit_reg;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_bit_reg <= fin10_reg;
        end
        else if (take)
        begin
            skid_bit_reg <= fin10_reg;
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_bit_reg};

    `CSO_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `CSO_ASSERT_NEXT(a_stall_fills_skid, out_valid_reg && !m_tready && take, skid_valid_reg)
    `CSO_ASSERT_NEXT(a_skid_drains, skid_valid_reg && m_tready, !skid_valid_reg && out_valid_reg)
endmodule
`default_nettype wire
